// File: rtl/cbs_pkg.sv
// Shared types, codes and constants of the chunked bump suballocator.
// No dependencies; used by the top level.
package cbs_pkg;

    localparam int MAX_CHUNKS_DEF = 16;
    localparam int SIZE_ALIGN_DEF = 256;
    localparam int SIZE_BITS_DEF  = 40;

    localparam int FW = 40;  // fixed payload field width
    localparam logic [FW-1:0] DEFAULT_CHUNK_RESET = 40'd4194304;

    // operations
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_SUBMIT = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // register indexes
    localparam logic [0:0] REG_DEFAULT = 1'd0;
    localparam logic [0:0] REG_LIMIT   = 1'd1;

    typedef struct packed {
        logic [1:0]    op;
        logic [FW-1:0] request_size;
        logic [4:0]    align_log2;
    } t_in;

    typedef struct packed {
        logic [1:0]    status;
        logic [3:0]    chunk_index;
        logic [FW-1:0] region_offset;
    } t_out;

endpackage

// File: rtl/cbs_cell.sv
// One pool slot: holds a chunk index and shifts it towards the head on request.
// Depends on nothing beyond its parameter.
module cbs_cell #(
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [IW-1:0] i_load_val,
    input  logic          i_shift,
    input  logic [IW-1:0] i_next_val,
    output logic [IW-1:0] o_val
);
    logic [IW-1:0] r_val;

    // load has priority, shift pulls from the neighbour behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_load) begin
            r_val <= i_load_val;
        end else if (i_shift) begin
            r_val <= i_next_val;
        end
    end

    assign o_val = r_val;
endmodule

// File: rtl/chunked_bump_suballocator_top.sv
// Chunked bump suballocator: top level with sequencer, chunk tables and pool cells.
// Depends on cbs_pkg and cbs_cell.
//
// One transaction at a time. Submit, unused ops and an allocate that fits the
// current chunk go from the bump state straight to the output state. Any other
// allocate runs a first-fit scan, the removal of the hit entry if there is one,
// and the new-chunk states S_NEW and S_NEW2; the first-fit scan and the removal
// together pass over the pool once. A fill reset passes over the pool once to
// clear the fill of each pooled chunk. The pool is a row of cells; when an entry
// is removed, the entries behind it move one place towards the head, one cell at
// a time. The result sits in an output register; the next transaction is taken
// once it has been delivered. No clearing pass after reset.
module chunked_bump_suballocator_top #(
    parameter int MAX_CHUNKS = cbs_pkg::MAX_CHUNKS_DEF,
    parameter int SIZE_ALIGN = cbs_pkg::SIZE_ALIGN_DEF,
    parameter int SIZE_BITS  = cbs_pkg::SIZE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  cbs_pkg::t_in                 i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output cbs_pkg::t_out                o_data,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_index,
    input  logic [cbs_pkg::FW-1:0]       i_cfg_data
);
    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int SB = SIZE_BITS;
    localparam int AL = (SIZE_ALIGN > 1) ? $clog2(SIZE_ALIGN) : 0;
    localparam logic [SB:0] VMASK = {1'b0, {SB{1'b1}}};
    localparam int FW = cbs_pkg::FW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_BUMP  = 8'b00000010,
        S_SCAN  = 8'b00000100,
        S_SHIFT = 8'b00001000,
        S_NEW   = 8'b00010000,
        S_NEW2  = 8'b00100000,
        S_CLR   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [FW-1:0] r_def, r_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def <= cbs_pkg::DEFAULT_CHUNK_RESET;
            r_lim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbs_pkg::REG_DEFAULT: r_def <= i_cfg_data;
                cbs_pkg::REG_LIMIT:   r_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // chunk tables (undefined until written)
    logic [SB-1:0] r_cap  [MAX_CHUNKS];
    logic [SB-1:0] r_fill [MAX_CHUNKS];

    logic          r_cur_valid;
    logic [IW-1:0] r_cur;
    logic [CW-1:0] r_created, r_pcount, r_i;
    logic [SB-1:0] r_total, r_size;
    logic [4:0]    r_lg;
    logic [1:0]    r_op;
    logic          r_have_ret;
    logic [IW-1:0] r_ret;
    logic [SB:0]   r_sz;
    logic          r_sz_ovf;
    cbs_pkg::t_out r_out;

    // pool cells
    logic [IW-1:0] w_pool [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] w_load, w_shift;
    logic [IW-1:0] w_load_val;

    for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_pool
        logic [IW-1:0] w_next;
        if (g == MAX_CHUNKS - 1) begin : g_last
            assign w_next = w_pool[g];
        end else begin : g_mid
            assign w_next = w_pool[g+1];
        end
        cbs_cell #(.IW(IW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_load(w_load[g]), .i_load_val(w_load_val),
            .i_shift(w_shift[g]), .i_next_val(w_next),
            .o_val(w_pool[g])
        );
    end

    // current chunk bump check
    logic [IW-1:0] w_i;
    logic [SB+32:0] w_amask, w_f, w_alg, w_end;
    logic           w_fit;
    assign w_amask = ({{(SB+1){1'b0}}, 32'd1} << r_lg) - 1'b1;
    assign w_f     = {{33{1'b0}}, r_fill[r_cur]};
    assign w_alg   = (w_f + w_amask) & ~w_amask;
    assign w_end   = w_alg + {{33{1'b0}}, r_size};
    assign w_fit   = (w_end <= {{33{1'b0}}, r_cap[r_cur]});

    assign w_i = r_i[IW-1:0];
    logic [IW-1:0] w_pc;
    logic w_hit;
    assign w_pc  = w_pool[w_i];
    assign w_hit = (r_fill[w_pc] == '0) && (r_cap[w_pc] >= r_size);

    // new chunk size: ceil(max(size,default)/SIZE_ALIGN)*SIZE_ALIGN
    logic [SB-1:0] w_dsz, w_base;
    logic [SB:0]   w_rnd;
    assign w_dsz  = SB'(r_def);
    assign w_base = (r_size > w_dsz) ? r_size : w_dsz;
    assign w_rnd  = ({1'b0, w_base} + (SB+1)'(SIZE_ALIGN - 1)) >> AL << AL;

    logic w_lim_bad, w_ovf_total;
    logic [SB:0] w_sum;
    assign w_sum       = {1'b0, r_total} + r_sz;
    assign w_lim_bad   = (r_sz > (SB+1)'(r_lim)) || (w_sum > (SB+1)'(r_lim));
    assign w_ovf_total = w_sum > VMASK;

    // sequencer
    always_comb begin
        n_state    = r_state;
        w_load     = '0;
        w_shift    = '0;
        w_load_val = r_ret;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_BUMP;
            S_BUMP: begin
                if (r_op == cbs_pkg::OP_ALLOC)
                    n_state = (r_cur_valid && w_fit) ? S_OUT : S_SCAN;
                else if (r_op == cbs_pkg::OP_RESET)
                    n_state = S_CLR;
                else
                    n_state = S_OUT;
            end
            S_SCAN: begin
                if (r_i >= r_pcount) n_state = S_NEW;
                else if (w_hit) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_i + 1'b1 < r_pcount) w_shift[w_i] = 1'b1;
                else n_state = S_NEW;
            end
            S_NEW:   n_state = S_NEW2;
            S_NEW2:  n_state = S_OUT;
            S_CLR:   if (r_i >= r_pcount) n_state = S_OUT;
            S_OUT:   if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // push of the retired chunk, after any removal
        if (r_state == S_NEW && r_have_ret && r_pcount < CW'(MAX_CHUNKS))
            w_load[r_pcount[IW-1:0]] = 1'b1;
        if (r_state == S_BUMP && r_op == cbs_pkg::OP_SUBMIT && r_cur_valid
            && r_pcount < CW'(MAX_CHUNKS)) begin
            w_load_val = r_cur;
            w_load[r_pcount[IW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_created   <= '0;
            r_pcount    <= '0;
            r_total     <= '0;
            r_have_ret  <= 1'b0;
            r_i         <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op       <= i_data.op;
                    r_size     <= SB'(i_data.request_size);
                    r_lg       <= i_data.align_log2;
                    r_have_ret <= 1'b0;
                    r_i        <= '0;
                    r_out      <= '0;
                end
                S_BUMP: begin
                    if (r_op == cbs_pkg::OP_ALLOC) begin
                        if (r_cur_valid && w_fit) begin
                            r_fill[r_cur] <= w_end[SB-1:0];
                            r_out.chunk_index   <= 4'(r_cur);
                            r_out.region_offset <= FW'(w_alg[SB-1:0]);
                        end else if (r_cur_valid) begin
                            r_have_ret  <= 1'b1;
                            r_ret       <= r_cur;
                            r_cur_valid <= 1'b0;
                        end
                    end else if (r_op == cbs_pkg::OP_SUBMIT && r_cur_valid) begin
                        if (r_pcount < CW'(MAX_CHUNKS)) r_pcount <= r_pcount + 1'b1;
                        r_cur_valid <= 1'b0;
                    end else if (r_op == cbs_pkg::OP_RESET && r_cur_valid) begin
                        r_fill[r_cur] <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_i < r_pcount) begin
                        if (w_hit) begin
                            r_cur_valid <= 1'b1;
                            r_cur       <= w_pc;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_i + 1'b1 < r_pcount) r_i <= r_i + 1'b1;
                    else r_pcount <= r_pcount - 1'b1;
                end
                S_NEW: begin
                    if (r_have_ret && r_pcount < CW'(MAX_CHUNKS))
                        r_pcount <= r_pcount + 1'b1;
                    r_sz     <= w_rnd;
                    r_sz_ovf <= w_rnd > VMASK;
                end
                S_NEW2: begin
                    if (r_cur_valid) begin
                        r_fill[r_cur]     <= r_size;
                        r_out.chunk_index <= 4'(r_cur);
                    end else if (r_sz_ovf) begin
                        r_out.status <= cbs_pkg::ST_OVERFLOW;
                    end else if (r_lim != '0 && w_lim_bad) begin
                        r_out.status <= cbs_pkg::ST_LIMIT;
                    end else if (r_lim == '0 && w_ovf_total) begin
                        r_out.status <= cbs_pkg::ST_OVERFLOW;
                    end else if (r_created >= CW'(MAX_CHUNKS)) begin
                        r_out.status <= cbs_pkg::ST_FULL;
                    end else begin
                        r_cap[r_created[IW-1:0]]  <= r_sz[SB-1:0];
                        r_fill[r_created[IW-1:0]] <= r_size;
                        r_created         <= r_created + 1'b1;
                        r_total           <= w_sum[SB-1:0];
                        r_cur_valid       <= 1'b1;
                        r_cur             <= r_created[IW-1:0];
                        r_out.chunk_index <= 4'(r_created[IW-1:0]);
                    end
                end
                S_CLR: begin
                    if (r_i < r_pcount) begin
                        r_fill[w_pc] <= '0;
                        r_i          <= r_i + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    // a result only ever follows an accepted transaction
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state != S_IDLE))
        else $error("result without transaction");
    // pool never exceeds the table
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= CW'(MAX_CHUNKS) && r_created <= CW'(MAX_CHUNKS))
        else $error("pool or chunk count overrun");
    // a granted allocate names a created chunk
    a_idx_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_op == cbs_pkg::OP_ALLOC && o_data.status == cbs_pkg::ST_OK)
        |-> (CW'(o_data.chunk_index) < r_created))
        else $error("grant from uncreated chunk");
endmodule
